FILE: rtl/svg_pkg.sv
package svg_pkg;

  // Field widths
  localparam int unsigned SEG_W  = 11;
  localparam int unsigned RAD_W  = 16;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned TEX_W  = 16;
  localparam int unsigned TRIG_W = 16;
  localparam int unsigned PH_W   = 16;

  // Long division: dividend width, quotient bits, quotient bits per stage
  localparam int unsigned DIV_DW  = 28;
  localparam int unsigned DIV_QW  = 18;
  localparam int unsigned DIV_PER = 2;
  localparam int unsigned DIV_NS  = DIV_QW / DIV_PER;

  // Rotation CORDIC
  localparam int unsigned CORDIC_N  = 15;
  localparam int unsigned CORDIC_W  = 18;
  localparam int unsigned CORDIC_NS = CORDIC_N + 2;
  localparam logic signed [CORDIC_W-1:0] GAIN_INIT = 18'sd19899;
  localparam logic signed [TRIG_W-1:0]   TRIG_MAX  = 16'sd32767;

  // Scaling multiplier stages
  localparam int unsigned SCL_NS = 3;

  // pi in Q2.14
  localparam logic [TEX_W-1:0] PI_Q14 = 16'd51472;

  // Register indexes
  localparam logic [1:0] CFG_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_LON_SEG = 2'd1;
  localparam logic [1:0] CFG_LAT_SEG = 2'd2;

  // Arctangent of 2^-i in 1/65536 turn
  function automatic logic [PH_W-1:0] atan_turn(input int unsigned i);
    logic [PH_W-1:0] a;
    case (i)
      0:       a = 16'd8192;
      1:       a = 16'd4836;
      2:       a = 16'd2555;
      3:       a = 16'd1297;
      4:       a = 16'd651;
      5:       a = 16'd326;
      6:       a = 16'd163;
      7:       a = 16'd81;
      8:       a = 16'd41;
      9:       a = 16'd20;
      10:      a = 16'd10;
      11:      a = 16'd5;
      12:      a = 16'd3;
      13:      a = 16'd1;
      14:      a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/svg_div.sv
module svg_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [svg_pkg::DIV_DW-1:0] dvd,
  input  logic [svg_pkg::SEG_W-1:0]  dsr,
  output logic [svg_pkg::DIV_QW-1:0] quo
);
  import svg_pkg::*;

  logic [SEG_W-1:0]  rem_r [DIV_NS];
  logic [DIV_QW-1:0] low_r [DIV_NS];
  logic [DIV_QW-1:0] q_r   [DIV_NS];

  for (genvar s = 0; s < DIV_NS; s++) begin : g_stage
    logic [SEG_W-1:0]  rem_nxt;
    logic [DIV_QW-1:0] low_nxt;
    logic [DIV_QW-1:0] q_nxt;

    // Restoring division, DIV_PER quotient bits per stage
    always_comb begin
      logic [SEG_W:0] t;
      if (s == 0) begin
        rem_nxt = SEG_W'(dvd[DIV_DW-1:DIV_QW]);
        low_nxt = dvd[DIV_QW-1:0];
        q_nxt   = '0;
      end else begin
        rem_nxt = rem_r[s-1];
        low_nxt = low_r[s-1];
        q_nxt   = q_r[s-1];
      end
      for (int k = 0; k < DIV_PER; k++) begin
        t       = {rem_nxt, low_nxt[DIV_QW-1]};
        low_nxt = {low_nxt[DIV_QW-2:0], 1'b0};
        if (t >= {1'b0, dsr}) begin
          t     = t - {1'b0, dsr};
          q_nxt = {q_nxt[DIV_QW-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[DIV_QW-2:0], 1'b0};
        end
        rem_nxt = t[SEG_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        low_r[s] <= low_nxt;
        q_r[s]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[DIV_NS-1];

endmodule

FILE: rtl/svg_cordic.sv
module svg_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic [svg_pkg::PH_W-1:0]          phase,
  output logic signed [svg_pkg::TRIG_W-1:0] sin_o,
  output logic signed [svg_pkg::TRIG_W-1:0] cos_o
);
  import svg_pkg::*;

  logic signed [CORDIC_W-1:0] x_r [CORDIC_N+1];
  logic signed [CORDIC_W-1:0] y_r [CORDIC_N+1];
  logic signed [CORDIC_W-1:0] z_r [CORDIC_N+1];
  logic                       flip_r [CORDIC_N+1];
  logic signed [TRIG_W-1:0]   sin_r, cos_r;

  // Fold the left half-plane onto the right one
  always_ff @(posedge clk) begin
    logic [PH_W-1:0] p;
    if (en) begin
      p = phase;
      if (phase >= 16'd16384 && phase < 16'd49152) begin
        p         = phase - 16'd32768;
        flip_r[0] <= 1'b1;
      end else begin
        flip_r[0] <= 1'b0;
      end
      z_r[0] <= CORDIC_W'($signed(p));
      x_r[0] <= GAIN_INIT;
      y_r[0] <= '0;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] dx, dy, at;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign at = CORDIC_W'(atan_turn(i));

    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][CORDIC_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  // Saturate, then undo the fold
  function automatic logic signed [TRIG_W-1:0] sat(input logic signed [CORDIC_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > CORDIC_W'(TRIG_MAX))       r = TRIG_MAX;
    else if (v < -CORDIC_W'(TRIG_MAX)) r = -TRIG_MAX;
    else                               r = v[TRIG_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (flip_r[CORDIC_N]) begin
        sin_r <= -sat(y_r[CORDIC_N]);
        cos_r <= -sat(x_r[CORDIC_N]);
      end else begin
        sin_r <= sat(y_r[CORDIC_N]);
        cos_r <= sat(x_r[CORDIC_N]);
      end
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: rtl/svg_scale.sv
module svg_scale (
  input  logic                              clk,
  input  logic                              en,
  input  logic [svg_pkg::RAD_W-1:0]         radius,
  input  logic signed [svg_pkg::TRIG_W-1:0] sin_t,
  input  logic signed [svg_pkg::TRIG_W-1:0] cos_t,
  input  logic signed [svg_pkg::TRIG_W-1:0] sin_p,
  input  logic signed [svg_pkg::TRIG_W-1:0] cos_p,
  output logic signed [svg_pkg::POS_W-1:0]  pos_x,
  output logic signed [svg_pkg::POS_W-1:0]  pos_y,
  output logic signed [svg_pkg::POS_W-1:0]  pos_z
);
  import svg_pkg::*;

  localparam int unsigned PW = 2 * TRIG_W;
  localparam int unsigned YW = RAD_W + 1 + TRIG_W;
  localparam int unsigned XW = RAD_W + 1 + PW;

  logic signed [RAD_W:0]  rad_s;
  logic signed [PW-1:0]   sc_r, ss_r;
  logic signed [YW-1:0]   ya_r, yb_r;
  logic signed [XW-1:0]   xb_r, zb_r;
  logic signed [POS_W-1:0] x_r, y_r, z_r;

  assign rad_s = $signed({1'b0, radius});

  // Round to nearest, halves away from zero
  function automatic logic signed [POS_W-1:0] rnd30(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = v + XW'(1 << 29) - XW'(v[XW-1]);
    t = t >>> 30;
    return t[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] rnd15(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] t;
    t = v + YW'(1 << 14) - YW'(v[YW-1]);
    t = t >>> 15;
    return t[POS_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // trig products and radius times cos theta
      sc_r <= sin_t * cos_p;
      ss_r <= sin_t * sin_p;
      ya_r <= rad_s * cos_t;
      // radius times the products
      xb_r <= rad_s * sc_r;
      zb_r <= rad_s * ss_r;
      yb_r <= ya_r;
      // round
      x_r  <= rnd30(xb_r);
      z_r  <= rnd30(zb_r);
      y_r  <= rnd15(yb_r);
    end
  end

  assign pos_x = x_r;
  assign pos_y = y_r;
  assign pos_z = z_r;

endmodule

FILE: rtl/sphere_vertex_generator.sv
// UV-sphere vertex generator. Each input word carries a longitude and a
// latitude grid index; the block returns one vertex word per input: the
// Q8.8 position (which is also the normal) and the Q2.14 texture angles,
// with tuser set when an index lay beyond its segment count and was clamped.
// The datapath is a 30-stage pipeline: one input register, nine stages of
// long division (two quotient bits a stage) for the angles, seventeen
// stages of rotation CORDIC and three stages of scaling multipliers. It
// takes one word every cycle unless back-pressure on the output stalls
// the whole pipeline. Registers may only be written while no word is in
// flight.
module sphere_vertex_generator #(
  parameter int unsigned MAX_SEGMENTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // lon_index[10:0], lat_index[21:11]
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic        out_tuser   // index_clamped
);
  import svg_pkg::*;

  localparam int unsigned LAT  = 1 + DIV_NS + CORDIC_NS + SCL_NS;
  localparam int unsigned TEXD = CORDIC_NS + SCL_NS;

  logic [RAD_W-1:0] radius_r;
  logic [SEG_W-1:0] lon_seg_r, lat_seg_r;

  // Effective segment count: zero acts as one, large counts are capped
  function automatic logic [SEG_W-1:0] eff_seg(input logic [SEG_W-1:0] v);
    logic [SEG_W-1:0] r;
    if (v == '0)                      r = SEG_W'(1);
    else if (32'(v) > MAX_SEGMENTS)   r = SEG_W'(MAX_SEGMENTS);
    else                              r = v;
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RAD_W'(256);
      lon_seg_r <= eff_seg(SEG_W'(64));
      lat_seg_r <= eff_seg(SEG_W'(64));
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RADIUS:  radius_r  <= cfg_wdata;
        CFG_LON_SEG: lon_seg_r <= eff_seg(cfg_wdata[SEG_W-1:0]);
        CFG_LAT_SEG: lat_seg_r <= eff_seg(cfg_wdata[SEG_W-1:0]);
        default:     ;
      endcase
    end
  end

  // Global advance: the whole pipeline moves unless the output word is held
  logic en;
  logic vld_r [LAT];
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Input stage: clamp the indexes
  logic [SEG_W-1:0] lon_in, lat_in, lon_r, lat_r;
  logic             clamp_r [LAT];
  assign lon_in = in_tdata[SEG_W-1:0];
  assign lat_in = in_tdata[2*SEG_W-1:SEG_W];

  always_ff @(posedge clk) begin
    if (en) begin
      lon_r      <= (lon_in > lon_seg_r) ? lon_seg_r : lon_in;
      lat_r      <= (lat_in > lat_seg_r) ? lat_seg_r : lat_in;
      clamp_r[0] <= (lon_in > lon_seg_r) || (lat_in > lat_seg_r);
      for (int i = 1; i < LAT; i++) clamp_r[i] <= clamp_r[i-1];
    end
  end

  // Angle dividends
  logic [DIV_DW-1:0] tph_dvd, pph_dvd, tu_dvd, tv_dvd;
  logic [DIV_QW-1:0] tph_q, pph_q, tu_q, tv_q;
  assign tph_dvd = (DIV_DW'(lat_r) << 15) + DIV_DW'(lat_seg_r >> 1);
  assign pph_dvd = (DIV_DW'(lon_r) << 16) + DIV_DW'(lon_seg_r >> 1);
  assign tu_dvd  = DIV_DW'(lon_r) * DIV_DW'(PI_Q14) + DIV_DW'(lon_seg_r >> 1);
  assign tv_dvd  = DIV_DW'(lat_r) * DIV_DW'(PI_Q14) + DIV_DW'(lat_seg_r >> 1);

  svg_div u_div_tph (.clk, .en, .dvd(tph_dvd), .dsr(lat_seg_r), .quo(tph_q));
  svg_div u_div_pph (.clk, .en, .dvd(pph_dvd), .dsr(lon_seg_r), .quo(pph_q));
  svg_div u_div_tu  (.clk, .en, .dvd(tu_dvd),  .dsr(lon_seg_r), .quo(tu_q));
  svg_div u_div_tv  (.clk, .en, .dvd(tv_dvd),  .dsr(lat_seg_r), .quo(tv_q));

  // Carry the texture angles alongside the trig
  logic [TEX_W-1:0] tu_r [TEXD];
  logic [TEX_W-1:0] tv_r [TEXD];
  always_ff @(posedge clk) begin
    if (en) begin
      tu_r[0] <= tu_q[TEX_W-1:0];
      tv_r[0] <= tv_q[TEX_W-1:0];
      for (int i = 1; i < TEXD; i++) begin
        tu_r[i] <= tu_r[i-1];
        tv_r[i] <= tv_r[i-1];
      end
    end
  end

  // Sine and cosine of theta and phi
  logic signed [TRIG_W-1:0] st, ct, sp, cp;
  svg_cordic u_cor_t (.clk, .en, .phase(tph_q[PH_W-1:0]), .sin_o(st), .cos_o(ct));
  svg_cordic u_cor_p (.clk, .en, .phase(pph_q[PH_W-1:0]), .sin_o(sp), .cos_o(cp));

  // Scale by the radius
  logic signed [POS_W-1:0] px, py, pz;
  svg_scale u_scale (
    .clk, .en, .radius(radius_r),
    .sin_t(st), .cos_t(ct), .sin_p(sp), .cos_p(cp),
    .pos_x(px), .pos_y(py), .pos_z(pz)
  );

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {5'd0, tv_r[TEXD-1], tu_r[TEXD-1], pz, py, px};
  assign out_tuser  = clamp_r[LAT-1];

endmodule

FILE: rtl/svg_checker.sv
module svg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        out_tuser
);

  // A held output word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // Input is taken whenever the output side can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // Pipeline is empty after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Texture angles stay within pi
  a_tex: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[66:51] <= 16'd51472) && (out_tdata[82:67] <= 16'd51472))
    else $error("texture angle above pi");

endmodule

bind sphere_vertex_generator svg_checker u_svg_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import svg_pkg::*;

  // register index with no register behind it
  localparam logic [1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [10:0] lon;
    logic [10:0] lat;
  } grid_pt_t;

  typedef struct packed {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
    logic [15:0]        tu;
    logic [15:0]        tv;
    logic               clamped;
  } vertex_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        out_tuser;

  sphere_vertex_generator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // predictor's copy of the registers
  logic [15:0] m_radius;
  logic [10:0] m_lon_seg;
  logic [10:0] m_lat_seg;

  grid_pt_t pending_pts[$];
  vertex_t  vertex_q[$];
  int       n_errors;
  bit       stim_done;
  int       hold_off;    // long receiver stall, counted down by the monitor
  int       in_gap;
  int       out_gap;

  const int ATAN_T[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3,
                           1, 1};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int fshift(int v, int s);
    if (v >= 0) return v >>> s;
    return ~((~v) >>> s);
  endfunction

  // rotation CORDIC on a phase in 1/65536 turn
  function automatic void sin_cos(int unsigned ph, output int s, output int c);
    int x, y, z, dx, dy;
    bit flip;
    x = 19899; y = 0; flip = 0;
    ph = ph & 16'hFFFF;
    if (ph >= 16384 && ph < 49152) begin
      ph = (ph - 32768) & 16'hFFFF;
      flip = 1;
    end
    z = (ph >= 32768) ? int'(ph) - 65536 : int'(ph);
    for (int i = 0; i < 15; i++) begin
      dx = fshift(y, i); dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_T[i];
      end else begin
        x += dx; y -= dy; z += ATAN_T[i];
      end
    end
    if (x > 32767) x = 32767;
    if (x < -32767) x = -32767;
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    if (flip) begin
      x = -x; y = -y;
    end
    s = y; c = x;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic int unsigned seg_eff(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic vertex_t sphere_point(grid_pt_t p);
    vertex_t r;
    int unsigned m, n, lon, lat, tph, pph;
    int st, ct, sp, cp;
    longint rad;
    m = seg_eff(m_lon_seg); n = seg_eff(m_lat_seg);
    lon = p.lon; lat = p.lat; r.clamped = 0;
    rad = m_radius;
    if (lon > m) begin
      lon = m; r.clamped = 1;
    end
    if (lat > n) begin
      lat = n; r.clamped = 1;
    end
    tph = (lat * 32768 + n / 2) / n;
    pph = ((lon * 65536 + m / 2) / m) & 16'hFFFF;
    sin_cos(tph, st, ct);
    sin_cos(pph, sp, cp);
    r.px = rnd_shift(rad * (longint'(st) * cp), 30);
    r.py = rnd_shift(rad * longint'(ct), 15);
    r.pz = rnd_shift(rad * (longint'(st) * sp), 30);
    r.tu = (lon * 51472 + m / 2) / m;
    r.tv = (lat * 51472 + n / 2) / n;
    return r;
  endfunction

  // driver: offer the head of the queue, with random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold
    end else begin
      if (in_tvalid) begin
        vertex_q.insert(vertex_q.size(), sphere_point(pending_pts.pop_front()));
      end
      if (in_tvalid && pending_pts.size() > 0 && $urandom_range(0, 2) == 0) begin
        in_tdata <= {2'b00, pending_pts[0].lat, pending_pts[0].lon};
      end else if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        in_tdata  <= {2'b00, pending_pts[0].lat, pending_pts[0].lon};
        in_tvalid <= 1'b1;
        in_gap    <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each vertex word with the oldest prediction
  always @(posedge clk) begin
    vertex_t e, a;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        a.px = out_tdata[16:0];  a.py = out_tdata[33:17];
        a.pz = out_tdata[50:34]; a.tu = out_tdata[66:51];
        a.tv = out_tdata[82:67]; a.clamped = out_tuser;
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex word %h", out_tdata);
          n_errors++;
        end else begin
          e = vertex_q.pop_front();
          if (a.px !== e.px) begin
            $error("pos_x expected %0d actual %0d", e.px, a.px); n_errors++;
          end
          if (a.py !== e.py) begin
            $error("pos_y expected %0d actual %0d", e.py, a.py); n_errors++;
          end
          if (a.pz !== e.pz) begin
            $error("pos_z expected %0d actual %0d", e.pz, a.pz); n_errors++;
          end
          if (a.tu !== e.tu) begin
            $error("tex_u expected %0d actual %0d", e.tu, a.tu); n_errors++;
          end
          if (a.tv !== e.tv) begin
            $error("tex_v expected %0d actual %0d", e.tv, a.tv); n_errors++;
          end
          if (a.clamped !== e.clamped) begin
            $error("index_clamped expected %0d actual %0d", e.clamped, a.clamped);
            n_errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off   <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && $urandom_range(0, 3) == 0) out_gap <= $urandom_range(0, 14);
      end
    end
  end

  task automatic wait_idle();
    while (pending_pts.size() > 0 || in_tvalid || vertex_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_RADIUS:  m_radius  = val;
      CFG_LON_SEG: m_lon_seg = val[10:0];
      CFG_LAT_SEG: m_lat_seg = val[10:0];
      default: ;
    endcase
  endtask

  task automatic push_pt(int unsigned lon, int unsigned lat);
    grid_pt_t p;
    p.lon = lon; p.lat = lat;
    pending_pts.insert(pending_pts.size(), p);
  endtask

  // mostly in-range grid points, some beyond the counts, some anywhere
  task automatic random_pts(int cnt);
    int unsigned m, n;
    m = seg_eff(m_lon_seg); n = seg_eff(m_lat_seg);
    repeat (cnt) begin
      case ($urandom_range(0, 9))
        0:       push_pt($urandom_range(0, 2047), $urandom_range(0, 2047));
        1:       push_pt($urandom_range(0, m + 3), $urandom_range(0, n + 3));
        default: push_pt($urandom_range(0, m), $urandom_range(0, n));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    out_tready = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    m_radius = 256; m_lon_seg = 64; m_lat_seg = 64;
    n_errors = 0; stim_done = 0; hold_off = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: poles, seam, quadrants, clamping, at reset settings
    push_pt(0, 0); push_pt(0, 64); push_pt(64, 32); push_pt(16, 32);
    push_pt(32, 32); push_pt(48, 32); push_pt(65, 10); push_pt(10, 65);
    push_pt(2047, 2047); push_pt(1024, 1024);
    wait_idle();
    // zero counts act as one, out-of-range register index ignored
    write_reg(CFG_LON_SEG, 0); write_reg(CFG_LAT_SEG, 0);
    write_reg(CFG_NONE, 16'h1234);
    push_pt(0, 0); push_pt(1, 1); push_pt(2, 0);
    wait_idle();
    // counts above the limit, largest radius
    write_reg(CFG_RADIUS, 16'hFFFF);
    write_reg(CFG_LON_SEG, 2047); write_reg(CFG_LAT_SEG, 1025);
    push_pt(1024, 1024); push_pt(512, 512); push_pt(1025, 0); push_pt(256, 1023);
    push_pt(0, 2047);
    wait_idle();

    // stall the receiver long while the sender keeps offering
    hold_off = 300;
    random_pts(100);
    wait_idle();

    // random phases, extremes among the settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(CFG_RADIUS, 0);
        1: write_reg(CFG_RADIUS, 16'hFFFF);
        default: write_reg(CFG_RADIUS, $urandom_range(0, 65535));
      endcase
      case (ph)
        0: write_reg(CFG_LON_SEG, 1);
        1: write_reg(CFG_LON_SEG, 1024);
        2: write_reg(CFG_LON_SEG, 2047);
        default: write_reg(CFG_LON_SEG, $urandom_range(1, 1024));
      endcase
      case (ph)
        0: write_reg(CFG_LAT_SEG, 1024);
        1: write_reg(CFG_LAT_SEG, 1);
        2: write_reg(CFG_LAT_SEG, 0);
        default: write_reg(CFG_LAT_SEG, $urandom_range(1, 1024));
      endcase
      random_pts(240);
      wait_idle();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
